/* hdl/lps_pkg.sv */
// shared types and constants for the lru page slot cache
// no dependencies; imported by lps_cell and lru_page_slot_cache
`timescale 1ns / 1ps

package lps_pkg;

  localparam int SLOTS      = 8;
  localparam int INDEX_BITS = 16;
  localparam int STAMP_BITS = 32;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // widths fixed by the stream fields
  localparam int PAGE_W      = 16;
  localparam int OUT_SLOT_W  = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  localparam logic CMD_ENSURE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef logic [SLOT_W-1:0]     slot_idx_t;
  typedef logic [INDEX_BITS-1:0] tag_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  // search token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic      active;
    tag_t      tag;
    logic      hit;
    slot_idx_t hit_idx;
    logic      inv_found;
    slot_idx_t inv_idx;
    logic      best_set;
    stamp_t    best_stamp;
    slot_idx_t best_idx;
    tag_t      best_tag;
  } scan_t;

  // entry update broadcast to every cell
  typedef struct packed {
    logic      clr;
    logic      wr;
    slot_idx_t idx;
    tag_t      tag;
    stamp_t    stamp;
  } cell_upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_t;

endpackage

/* hdl/lps_cell.sv */
// one cache entry plus one stage of the search token chain
// depends on lps_pkg
`timescale 1ns / 1ps

module lps_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lps_pkg::slot_idx_t my_idx,
  input  lps_pkg::scan_t     scan_i,
  input  lps_pkg::cell_upd_t upd,
  output lps_pkg::scan_t     scan_o
);
  import lps_pkg::*;

  logic   valid_r;
  tag_t   tag_r;
  stamp_t stamp_r;
  scan_t  scan_r;
  scan_t  scan_nxt;

  always_comb begin
    scan_nxt = scan_i;
    if (valid_r && (tag_r == scan_i.tag) && !scan_i.hit) begin
      scan_nxt.hit     = 1'b1;
      scan_nxt.hit_idx = my_idx;
    end
    if (!valid_r && !scan_i.inv_found) begin
      scan_nxt.inv_found = 1'b1;
      scan_nxt.inv_idx   = my_idx;
    end
    // strict compare keeps the lowest index on ties
    if (valid_r && (!scan_i.best_set || (stamp_r < scan_i.best_stamp))) begin
      scan_nxt.best_set   = 1'b1;
      scan_nxt.best_stamp = stamp_r;
      scan_nxt.best_idx   = my_idx;
      scan_nxt.best_tag   = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.active <= 1'b0;
    end else begin
      scan_r.active <= scan_nxt.active;
    end
    scan_r.tag        <= scan_nxt.tag;
    scan_r.hit        <= scan_nxt.hit;
    scan_r.hit_idx    <= scan_nxt.hit_idx;
    scan_r.inv_found  <= scan_nxt.inv_found;
    scan_r.inv_idx    <= scan_nxt.inv_idx;
    scan_r.best_set   <= scan_nxt.best_set;
    scan_r.best_stamp <= scan_nxt.best_stamp;
    scan_r.best_idx   <= scan_nxt.best_idx;
    scan_r.best_tag   <= scan_nxt.best_tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (upd.clr) begin
      valid_r <= 1'b0;
    end else if (upd.wr && (upd.idx == my_idx)) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.wr && (upd.idx == my_idx)) begin
      tag_r   <= upd.tag;
      stamp_r <= upd.stamp;
    end
  end

  assign scan_o = scan_r;

endmodule

/* hdl/lru_page_slot_cache.sv */
// top level of the fully associative page slot cache with timestamp lru
// depends on lps_pkg and lps_cell
`timescale 1ns / 1ps

// channel | dir | tdata (low bit up)                  | tuser (low bit up)
// in_     | in  | page_number[15:0]                   | command
// out_    | out | slot[2:0], evicted_page[18:3], pad  | hit, evicted_valid
//
// an ensure is accepted in idle; the search token then walks the cell chain
// (one cell a cycle) during scan, and finish updates the entry and loads the
// result register. a clear goes from accept straight to finish. one item is
// in flight at a time. reset (rst_n low, synchronous) invalidates every entry
// and sets the use counter to 1. a stalled result waits in the output register;
// the update is held back until that register is free.

module lru_page_slot_cache (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lps_pkg::IN_TDATA_W-1:0]     in_tdata,  // page_number
  input  logic                               in_tuser,  // command
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lps_pkg::OUT_TDATA_W-1:0]    out_tdata, // slot, evicted_page, zero pad
  output logic [lps_pkg::OUT_TUSER_W-1:0]    out_tuser  // hit, evicted_valid
);
  import lps_pkg::*;

  ctrl_state_t state_r, state_nxt;

  scan_t     chain [SLOTS+1];
  cell_upd_t upd;

  logic   cmd_r;
  scan_t  res_r;
  stamp_t use_count_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  logic      in_acc;
  logic      out_free;
  logic      commit;
  slot_idx_t victim;
  slot_idx_t target;
  logic      ev_valid;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser == CMD_CLEAR) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[SLOTS].active) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_SCAN:   ;
      ST_FINISH: commit = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // search token injected at the head of the chain
  always_comb begin
    chain[0]            = '0;
    chain[0].active     = in_acc && (in_tuser == CMD_ENSURE);
    chain[0].tag        = INDEX_BITS'(in_tdata);
  end

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      lps_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .my_idx (SLOT_W'(gi)),
        .scan_i (chain[gi]),
        .upd    (upd),
        .scan_o (chain[gi+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tuser;
    end
    if (chain[SLOTS].active) begin
      res_r <= chain[SLOTS];
    end
  end

  // victim: first invalid slot, else least recently stamped
  assign victim   = res_r.inv_found ? res_r.inv_idx : res_r.best_idx;
  assign target   = res_r.hit ? res_r.hit_idx : victim;
  assign ev_valid = !res_r.hit && !res_r.inv_found;

  always_comb begin
    upd       = '0;
    upd.clr   = commit && (cmd_r == CMD_CLEAR);
    upd.wr    = commit && (cmd_r == CMD_ENSURE);
    upd.idx   = target;
    upd.tag   = res_r.tag;
    upd.stamp = use_count_r;
  end

  // use counter wraps naturally at its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_count_r <= STAMP_BITS'(1);
    end else if (upd.clr) begin
      use_count_r <= STAMP_BITS'(1);
    end else if (upd.wr) begin
      use_count_r <= use_count_r + STAMP_BITS'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (cmd_r == CMD_CLEAR) begin
        out_data_r <= '0;
        out_user_r <= '0;
      end else begin
        out_data_r <= {(OUT_TDATA_W-PAGE_W-OUT_SLOT_W)'(0),
                       ev_valid ? PAGE_W'(res_r.best_tag) : PAGE_W'(0),
                       OUT_SLOT_W'(target)};
        out_user_r <= {ev_valid, res_r.hit};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
